// File: rtl/rbst_pkg.sv
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared constants and types for the ray / box slab test pipeline.
// ----------------------------------------------------------------------------
package rbst_pkg;

	// default number of fraction bits of the fixed-point format
	localparam int FRAC_BITS_DEF = 16;

	// coordinate width and slab numerator width
	localparam int CW_Q  = 32;
	localparam int NUM_W = CW_Q + 1;

	// quotient bits below the saturation point
	localparam int QW = 31;

	// divider stages: setup stage, one stage per quotient bit, result stage
	localparam int DIV_LAT = QW + 2;

	// register stages of the interval reduction
	localparam int RED_LAT = 3;

	// saturated infinity
	localparam logic signed [CW_Q-1:0] INF_Q = 32'sh7FFF_FFFF;
	localparam logic signed [CW_Q-1:0] NINF_Q = -32'sh7FFF_FFFF;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_BOX_MIN_X = 3'd0,
		REG_BOX_MIN_Y = 3'd1,
		REG_BOX_MIN_Z = 3'd2,
		REG_BOX_MAX_X = 3'd3,
		REG_BOX_MAX_Y = 3'd4,
		REG_BOX_MAX_Z = 3'd5,
		REG_PAR_THR   = 3'd6
	} reg_idx_t;

	// special-case control carried down the divider
	typedef struct packed {
		logic                   spec;
		logic signed [CW_Q-1:0] spec_val;
		logic                   neg;
		logic                   sat;
	} div_ctl_t;

endpackage

// File: rtl/rbst_slab_div.sv
// ----------------------------------------------------------------------------
// rbst_slab_div
// Pipelined slab distance: (|num| << FRAC_BITS) / |dir|, signed, saturated,
// one quotient bit per stage, with the parallel-axis case carried alongside.
// ----------------------------------------------------------------------------
module rbst_slab_div import rbst_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [CW_Q-1:0]  dir,
	input  logic                    par,
	input  logic                    on_max,
	output logic signed [CW_Q-1:0]  t
);

	localparam int DW = NUM_W + FRAC_BITS;
	localparam int SW = CW_Q + QW;
	localparam int XW = ((DW > SW) ? DW : SW) + 1;

	logic [NUM_W-1:0] anum;
	logic [CW_Q-1:0]  adir;
	logic [DW-1:0]    dvd;
	div_ctl_t         ctl_in;

	logic [DW-1:0]    rem_s [0:QW];
	logic [CW_Q-1:0]  dvs_s [0:QW];
	logic [QW-1:0]    quo_s [0:QW];
	div_ctl_t         ctl_s [0:QW];
	logic signed [CW_Q-1:0] t_q;

	// magnitudes and the shifted dividend
	assign anum = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign adir = dir[CW_Q-1] ? CW_Q'(-dir) : CW_Q'(dir);
	assign dvd  = {anum, {FRAC_BITS{1'b0}}};

	// special cases and saturation detect
	always_comb begin
		ctl_in.spec = par;
		if (num > 0)
			ctl_in.spec_val = INF_Q;
		else if (num < 0)
			ctl_in.spec_val = NINF_Q;
		else
			ctl_in.spec_val = on_max ? INF_Q : NINF_Q;
		ctl_in.neg = num[NUM_W-1] ^ dir[CW_Q-1];
		ctl_in.sat = XW'(dvd) >= XW'({adir, {QW{1'b0}}});
	end

	// setup stage
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= dvd;
			dvs_s[0] <= adir;
			quo_s[0] <= '0;
			ctl_s[0] <= ctl_in;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 1; j <= QW; j++) begin : g_bit
		localparam int BI = QW - j;
		logic [XW-1:0] sub;
		logic          ge;
		assign sub = XW'(dvs_s[j-1]) << BI;
		assign ge  = XW'(rem_s[j-1]) >= sub;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? DW'(XW'(rem_s[j-1]) - sub) : rem_s[j-1];
				dvs_s[j] <= dvs_s[j-1];
				quo_s[j] <= quo_s[j-1] | (ge ? (QW'(1) << BI) : '0);
				ctl_s[j] <= ctl_s[j-1];
			end
		end
	end

	// sign, saturation and parallel override
	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl_s[QW].spec)
				t_q <= ctl_s[QW].spec_val;
			else if (ctl_s[QW].sat)
				t_q <= ctl_s[QW].neg ? NINF_Q : INF_Q;
			else if (ctl_s[QW].neg)
				t_q <= CW_Q'(-$signed({1'b0, quo_s[QW]}));
			else
				t_q <= CW_Q'({1'b0, quo_s[QW]});
		end
	end

	assign t = t_q;

endmodule

// File: rtl/rbst_reduce.sv
// ----------------------------------------------------------------------------
// rbst_reduce
// Orders each axis pair, then takes the largest entry and smallest exit
// distance and forms the hit flag, over three register stages.
// ----------------------------------------------------------------------------
module rbst_reduce import rbst_pkg::*; (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [CW_Q-1:0] t_min [0:2],
	input  logic signed [CW_Q-1:0] t_max [0:2],
	output logic                   hit,
	output logic signed [CW_Q-1:0] t_near,
	output logic signed [CW_Q-1:0] t_far
);

	logic signed [CW_Q-1:0] lo_s1 [0:2];
	logic signed [CW_Q-1:0] hi_s1 [0:2];
	logic signed [CW_Q-1:0] near_s2, far_s2, m01, n01;
	logic signed [CW_Q-1:0] near_s3, far_s3;
	logic                   hit_s3;

	// order each pair
	for (genvar a = 0; a < 3; a++) begin : g_ax
		always_ff @(posedge clk) begin
			if (en) begin
				if (t_min[a] > t_max[a]) begin
					lo_s1[a] <= t_max[a];
					hi_s1[a] <= t_min[a];
				end else begin
					lo_s1[a] <= t_min[a];
					hi_s1[a] <= t_max[a];
				end
			end
		end
	end

	// largest minimum and smallest maximum
	assign m01 = (lo_s1[1] > lo_s1[0]) ? lo_s1[1] : lo_s1[0];
	assign n01 = (hi_s1[1] < hi_s1[0]) ? hi_s1[1] : hi_s1[0];
	always_ff @(posedge clk) begin
		if (en) begin
			near_s2 <= (lo_s1[2] > m01) ? lo_s1[2] : m01;
			far_s2  <= (hi_s1[2] < n01) ? hi_s1[2] : n01;
		end
	end

	// hit flag into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			near_s3 <= near_s2;
			far_s3  <= far_s2;
			hit_s3  <= near_s2 <= far_s2;
		end
	end

	assign hit    = hit_s3;
	assign t_near = near_s3;
	assign t_far  = far_s3;

endmodule

// File: rtl/ray_box_slab_test_core.sv
// ----------------------------------------------------------------------------
// ray_box_slab_test_core
// Ray against axis-aligned box slab test, one ray per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Takes one ray per cycle and returns one word per ray (one numerator
// stage, a 33-stage divider with one quotient bit per stage for each of
// the six slab planes, and three stages of ordering, reduction and hit
// compare). The whole pipeline moves together: it holds while a finished
// word waits at the output and s_tready is low in those cycles.
// Distances are signed fixed point with FRAC_BITS fraction bits; infinity is
// carried as +/-(2^31-1). The user must write box corners and the parallel
// threshold through the cfg port only while no ray is in flight (not enforced).
module ray_box_slab_test_core import rbst_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
	input  logic [191:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// t_near, t_far
	output logic [63:0]  m_tdata,
	// hit
	output logic         m_tuser,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_idx,
	input  logic [31:0]  cfg_data
);

	localparam int LAT = 1 + DIV_LAT + RED_LAT;

	logic signed [CW_Q-1:0] box_min_q [0:2];
	logic signed [CW_Q-1:0] box_max_q [0:2];
	logic [16:0]            thr_q;
	logic [LAT-1:0]         vld_q;
	logic                   en;

	logic signed [NUM_W-1:0] nmin_s1 [0:2];
	logic signed [NUM_W-1:0] nmax_s1 [0:2];
	logic signed [CW_Q-1:0]  dir_s1 [0:2];
	logic                    par_s1 [0:2];
	logic signed [CW_Q-1:0]  t_min [0:2];
	logic signed [CW_Q-1:0]  t_max [0:2];
	logic signed [CW_Q-1:0]  t_near, t_far;
	logic                    hit;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				box_min_q[i] <= -32'sd65536;
				box_max_q[i] <= 32'sd65536;
			end
			thr_q <= 17'd1;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_BOX_MIN_X: box_min_q[0] <= cfg_data;
				REG_BOX_MIN_Y: box_min_q[1] <= cfg_data;
				REG_BOX_MIN_Z: box_min_q[2] <= cfg_data;
				REG_BOX_MAX_X: box_max_q[0] <= cfg_data;
				REG_BOX_MAX_Y: box_max_q[1] <= cfg_data;
				REG_BOX_MAX_Z: box_max_q[2] <= cfg_data;
				REG_PAR_THR:   thr_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// pipeline advance and valid bits
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
	end

	// per axis: numerators, parallel flag, two dividers
	for (genvar a = 0; a < 3; a++) begin : g_axis
		logic signed [CW_Q-1:0] org, dir;
		logic [CW_Q-1:0]        adir;
		assign org  = s_tdata[a*CW_Q +: CW_Q];
		assign dir  = s_tdata[(a+3)*CW_Q +: CW_Q];
		assign adir = dir[CW_Q-1] ? CW_Q'(-dir) : CW_Q'(dir);

		always_ff @(posedge clk) begin
			if (en) begin
				nmin_s1[a] <= NUM_W'(box_min_q[a]) - NUM_W'(org);
				nmax_s1[a] <= NUM_W'(box_max_q[a]) - NUM_W'(org);
				dir_s1[a]  <= dir;
				par_s1[a]  <= (adir == '0) || (adir < CW_Q'(thr_q));
			end
		end

		rbst_slab_div #(.FRAC_BITS(FRAC_BITS)) u_div_min (
			.clk(clk), .en(en),
			.num(nmin_s1[a]), .dir(dir_s1[a]), .par(par_s1[a]),
			.on_max(1'b0), .t(t_min[a])
		);

		rbst_slab_div #(.FRAC_BITS(FRAC_BITS)) u_div_max (
			.clk(clk), .en(en),
			.num(nmax_s1[a]), .dir(dir_s1[a]), .par(par_s1[a]),
			.on_max(1'b1), .t(t_max[a])
		);
	end

	// interval reduction and hit
	rbst_reduce u_reduce (
		.clk(clk), .en(en),
		.t_min(t_min), .t_max(t_max),
		.hit(hit), .t_near(t_near), .t_far(t_far)
	);

	assign m_tdata = {t_far, t_near};
	assign m_tuser = hit;

	// a stalled word is never dropped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("word dropped");

	// saturation never yields the most negative code
	a_near_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> t_near != 32'sh8000_0000) else $error("t_near overflow");

	a_far_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> t_far != 32'sh8000_0000) else $error("t_far overflow");

	// input is taken exactly when the pipeline advances
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[0]) else $error("input lost");

endmodule
